FILE: hdl/cwe_pkg.sv
// shared types, constants and table functions of the constant-weight encoder
package cwe_pkg;

  localparam int LEN_W   = 13;
  localparam int WT_W    = 7;
  localparam int POS_W   = 12;
  localparam int BITS_W  = 4;
  localparam int NUM_W   = LEN_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [LEN_W-1:0] BASE_CAP = 13'd8191;
  localparam logic [LEN_W-1:0] LEN_RST  = 13'd2048;
  localparam logic [WT_W-1:0]  WT_RST   = 7'd32;

  localparam logic [CFG_IDX_W-1:0] REG_WORD_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT      = 1'b1;

  typedef enum logic [1:0] {
    PH_CHOOSE = 2'd0,
    PH_HEAD   = 2'd1,
    PH_TAIL   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             last;
  } res_word_t;

  // truncating power chain x, x*x, ... of t factors in q(f)
  function automatic logic [63:0] root_chain(input logic [63:0] x, input int t, input int f);
    logic [63:0] p;
    p = x;
    for (int k = 1; k < t; k++) p = (p * x) >> f;
    return p;
  endfunction

  // 1 - 2^(-1/t) in q(f), from the largest root whose chain stays at or below one half
  function automatic logic [63:0] root_comp(input int t, input int f);
    logic [63:0] one;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    one = 64'd1 << f;
    lo  = 64'd0;
    hi  = one - 64'd1;
    if (t < 1) return 64'd0;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      if (root_chain(mid, t, f) <= (one >> 1)) lo = mid;
      else hi = mid - 64'd1;
    end
    return one - lo;
  endfunction

endpackage

FILE: hdl/cwe_span.sv
// span of the next skip run: ceil((2n-t+1)(1-2^(-1/t))/2) clamped to [1, n-t]
module cwe_span #(
  parameter int MAX_WEIGHT         = 64,
  parameter int ROOT_FRACTION_BITS = 24
) (
  input  logic [cwe_pkg::LEN_W-1:0] length_left,
  input  logic [cwe_pkg::WT_W-1:0]  weight_left,
  output logic [cwe_pkg::LEN_W-1:0] span
);

  localparam int F   = ROOT_FRACTION_BITS;
  localparam int NW  = cwe_pkg::NUM_W;
  localparam int IW  = $clog2(MAX_WEIGHT + 1);
  localparam int PW  = NW + F;
  localparam logic [PW:0] RND = {{NW{1'b0}}, {(F + 1){1'b1}}};

  logic [F-1:0]               frac_tab [MAX_WEIGHT+1];
  logic [F-1:0]               frac;
  logic [NW-1:0]              num;
  logic [PW-1:0]              prod;
  logic [PW:0]                qsum;
  logic [NW-1:0]              q;
  logic [cwe_pkg::LEN_W-1:0]  lim;

  for (genvar g = 0; g <= MAX_WEIGHT; g++) begin : g_root
    localparam logic [F-1:0] FR = F'(cwe_pkg::root_comp(g, F));
    assign frac_tab[g] = FR;
  end

  assign frac = frac_tab[weight_left[IW-1:0]];
  assign num  = {length_left, 1'b1} - NW'(weight_left);
  assign prod = PW'(num) * PW'(frac);
  assign qsum = {1'b0, prod} + RND;
  assign q    = qsum[PW:F+1];
  assign lim  = length_left - cwe_pkg::LEN_W'(weight_left);

  always_comb begin
    if (length_left <= cwe_pkg::LEN_W'(weight_left)) begin
      span = cwe_pkg::LEN_W'(1);
    end else if (q == '0) begin
      span = cwe_pkg::LEN_W'(1);
    end else if (q > NW'(lim)) begin
      span = lim;
    end else begin
      span = q[cwe_pkg::LEN_W-1:0];
    end
  end

endmodule

FILE: hdl/cwe_out_buf.sv
// two-entry result buffer between the encoder core and the output channel
module cwe_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cwe_pkg::res_word_t push_word,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_stall,
  output cwe_pkg::res_word_t out_word
);

  logic               v0_r, v0_nxt;
  logic               v1_r, v1_nxt;
  cwe_pkg::res_word_t w0_r, w0_nxt;
  cwe_pkg::res_word_t w1_r, w1_nxt;
  logic               pop;

  assign pop       = v0_r && !out_stall;
  assign ready     = !v1_r;
  assign out_valid = v0_r;
  assign out_word  = w0_r;

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    w0_nxt = w0_r;
    w1_nxt = w1_r;
    if (v1_r) begin
      if (pop) begin
        w0_nxt = w1_r;
        v1_nxt = 1'b0;
      end
    end else if (v0_r) begin
      if (pop && push) begin
        w0_nxt = push_word;
      end else if (push) begin
        w1_nxt = push_word;
        v1_nxt = 1'b1;
      end else if (pop) begin
        v0_nxt = 1'b0;
      end
    end else if (push) begin
      w0_nxt = push_word;
      v0_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w0_r <= w0_nxt;
    w1_r <= w1_nxt;
  end

endmodule

FILE: hdl/constant_weight_encoder_top.sv
// constant-weight word encoder: message bits in, ascending set positions out
// a word's position is registered in the output buffer; a closing burst is set up in burst_r
// throughput: one message bit per cycle unless stalled; a closing burst of r positions
// holds in_stall, one position per cycle with buffer room, from the shared emit path
// reset: synchronous active-low; length 2048, weight 32, word restarted, buffer empty
module constant_weight_encoder_top #(
  parameter int MAX_LENGTH         = 4096,
  parameter int MAX_WEIGHT         = 64,
  parameter int ROOT_FRACTION_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cwe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cwe_pkg::LEN_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_message_bit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cwe_pkg::POS_W-1:0]     out_position,
  output logic                          out_last
);

  localparam int LW = cwe_pkg::LEN_W;
  localparam int WW = cwe_pkg::WT_W;
  localparam int NW = cwe_pkg::NUM_W;
  localparam int BW = cwe_pkg::BITS_W;
  localparam logic [LW-1:0] LEN_CAP = LW'((MAX_LENGTH < 8191) ? MAX_LENGTH : 8191);
  localparam logic [WW-1:0] WT_CAP  = WW'(MAX_WEIGHT);
  localparam logic [LW-1:0] LEN_RST_EFF =
    (cwe_pkg::LEN_RST > LEN_CAP) ? LEN_CAP : cwe_pkg::LEN_RST;
  localparam logic [WW-1:0] WT_RST_EFF =
    (cwe_pkg::WT_RST > WT_CAP) ? WT_CAP : cwe_pkg::WT_RST;

  function automatic logic [LW-1:0] eff_len(input logic [LW-1:0] wl);
    logic [LW-1:0] e;
    e = wl;
    if (wl == '0) e = LW'(1);
    else if (wl > LEN_CAP) e = LEN_CAP;
    return e;
  endfunction

  function automatic logic [WW-1:0] eff_wt(input logic [WW-1:0] wt);
    logic [WW-1:0] e;
    e = wt;
    if (wt == '0) e = WW'(1);
    else if (wt > WT_CAP) e = WT_CAP;
    return e;
  endfunction

  function automatic logic [BW-1:0] span_log2(input logic [LW-1:0] d);
    logic [BW-1:0] u;
    u = '0;
    for (int i = 0; i < LW; i++) begin
      if ((LW'(1) << i) < d) u = BW'(i + 1);
    end
    return u;
  endfunction

  logic [LW-1:0]   word_length_r, word_length_nxt;
  logic [WW-1:0]   weight_r, weight_nxt;
  logic [LW-1:0]   length_left_r, length_left_nxt;
  logic [WW-1:0]   weight_left_r, weight_left_nxt;
  logic [LW-1:0]   run_offset_r, run_offset_nxt;
  logic [LW-1:0]   base_r, base_nxt;
  logic [LW-1:0]   span_r, span_nxt;
  logic [BW-1:0]   bits_r, bits_nxt;
  logic [LW-1:0]   partial_r, partial_nxt;
  cwe_pkg::phase_t phase_r, phase_nxt;
  logic            burst_r, burst_nxt;

  logic [LW-1:0]   wl_sel;
  logic [WW-1:0]   wt_sel;
  logic            buf_ready;
  logic            accept;

  logic [LW-1:0]   span_d;
  logic [BW-1:0]   u_d;
  logic            len_le_wt;
  logic [LW-1:0]   len_after_skip;
  logic            skip_to_burst;
  logic [BW-1:0]   u_span;
  logic [NW-1:0]   pow_span;
  logic [LW-1:0]   pv_shift;
  logic [BW-1:0]   bits_dec;
  logic            head_done;
  logic            head_to_tail;
  logic [NW-1:0]   tail_c;

  logic            emit_req;
  logic [NW-1:0]   emit_gap;
  logic [NW-1:0]   emit_used;
  logic [NW:0]     emit_sum;
  logic [NW:0]     emit_next_base;
  logic [LW-1:0]   emit_lim;
  logic [LW-1:0]   emit_pos;
  logic [LW-1:0]   emit_base;
  logic [NW-1:0]   len_ext;
  logic [NW-1:0]   len_diff;
  logic [LW-1:0]   emit_len;
  logic [WW-1:0]   emit_wt;
  logic            emit_last;
  cwe_pkg::res_word_t emit_word;
  cwe_pkg::res_word_t out_word;

  cwe_span #(
    .MAX_WEIGHT         (MAX_WEIGHT),
    .ROOT_FRACTION_BITS (ROOT_FRACTION_BITS)
  ) u_span_calc (
    .length_left (length_left_r),
    .weight_left (weight_left_r),
    .span        (span_d)
  );

  cwe_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit_req),
    .push_word (emit_word),
    .ready     (buf_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_position = out_word.position;
  assign out_last     = out_word.last;

  assign in_stall = burst_r || !buf_ready;
  assign accept   = in_valid && !in_stall;

  // register write decode
  always_comb begin
    wl_sel = word_length_r;
    wt_sel = weight_r;
    if (cfg_we) begin
      unique case (cfg_index)
        cwe_pkg::REG_WORD_LENGTH: wl_sel = cfg_data;
        cwe_pkg::REG_WEIGHT:      wt_sel = cfg_data[WW-1:0];
        default: ;
      endcase
    end
  end

  // step conditions
  assign u_d            = span_log2(span_d);
  assign len_le_wt      = length_left_r <= LW'(weight_left_r);
  assign len_after_skip = length_left_r - span_d;
  assign skip_to_burst  = len_after_skip <= LW'(weight_left_r);
  assign u_span         = span_log2(span_r);
  assign pow_span       = NW'(1) << u_span;
  assign pv_shift       = {partial_r[LW-2:0], in_message_bit};
  assign bits_dec       = (bits_r == '0) ? '0 : bits_r - BW'(1);
  assign head_done      = bits_dec == '0;
  assign head_to_tail   = NW'(pv_shift) >= (pow_span - NW'(span_r));
  assign tail_c         = {partial_r, in_message_bit} + NW'(span_r) - pow_span;

  // emit request and its gap
  always_comb begin
    emit_req  = 1'b0;
    emit_gap  = '0;
    emit_used = NW'(1);
    if (burst_r) begin
      emit_req = buf_ready;
      emit_gap = NW'(run_offset_r);
    end else if (accept) begin
      unique case (phase_r)
        cwe_pkg::PH_HEAD: begin
          if (head_done && !head_to_tail) begin
            emit_req  = 1'b1;
            emit_gap  = NW'(run_offset_r) + NW'(pv_shift);
            emit_used = NW'(pv_shift) + NW'(1);
          end
        end
        cwe_pkg::PH_TAIL: begin
          emit_req  = 1'b1;
          emit_gap  = NW'(run_offset_r) + tail_c;
          emit_used = tail_c + NW'(1);
        end
        default: begin
          if (!len_le_wt && !in_message_bit && span_d == LW'(1)) begin
            emit_req = 1'b1;
            emit_gap = NW'(run_offset_r);
          end
        end
      endcase
    end
  end

  // one position: saturated index, advanced base, shrunk length and weight, last flag
  assign emit_sum       = (NW + 1)'(base_r) + (NW + 1)'(emit_gap);
  assign emit_next_base = emit_sum + (NW + 1)'(1);
  assign emit_lim       = eff_len(word_length_r) - LW'(1);
  assign emit_pos       = (emit_sum > (NW + 1)'(emit_lim)) ? emit_lim : emit_sum[LW-1:0];
  assign emit_base      = (emit_next_base > (NW + 1)'(cwe_pkg::BASE_CAP)) ?
                          cwe_pkg::BASE_CAP : emit_next_base[LW-1:0];
  assign len_ext        = NW'(length_left_r);
  assign len_diff       = len_ext - emit_used;
  assign emit_len       = (len_ext > emit_used) ? len_diff[LW-1:0] : '0;
  assign emit_wt        = (weight_left_r == '0) ? '0 : weight_left_r - WW'(1);
  assign emit_last      = emit_wt == '0;

  assign emit_word.position = emit_pos[cwe_pkg::POS_W-1:0];
  assign emit_word.last     = emit_last;

  always_comb begin
    word_length_nxt = wl_sel;
    weight_nxt      = wt_sel;
    length_left_nxt = length_left_r;
    weight_left_nxt = weight_left_r;
    run_offset_nxt  = run_offset_r;
    base_nxt        = base_r;
    span_nxt        = span_r;
    bits_nxt        = bits_r;
    partial_nxt     = partial_r;
    phase_nxt       = phase_r;
    burst_nxt       = burst_r;

    if (accept) begin
      unique case (phase_r)
        cwe_pkg::PH_HEAD: begin
          partial_nxt = pv_shift;
          bits_nxt    = bits_dec;
          if (head_done) phase_nxt = cwe_pkg::PH_TAIL;
        end
        cwe_pkg::PH_TAIL: begin
          phase_nxt = cwe_pkg::PH_CHOOSE;
        end
        default: begin
          phase_nxt = cwe_pkg::PH_CHOOSE;
          if (len_le_wt) begin
            burst_nxt = 1'b1;
          end else if (in_message_bit) begin
            length_left_nxt = len_after_skip;
            run_offset_nxt  = run_offset_r + span_d;
            if (skip_to_burst) burst_nxt = 1'b1;
          end else begin
            span_nxt = span_d;
            if (span_d != LW'(1)) begin
              partial_nxt = '0;
              bits_nxt    = u_d - BW'(1);
              phase_nxt   = (u_d == BW'(1)) ? cwe_pkg::PH_TAIL : cwe_pkg::PH_HEAD;
            end
          end
        end
      endcase
    end

    if (emit_req) begin
      base_nxt        = emit_base;
      length_left_nxt = emit_len;
      weight_left_nxt = emit_wt;
      run_offset_nxt  = '0;
      phase_nxt       = cwe_pkg::PH_CHOOSE;
    end

    // word restart after the last position or on a register write
    if ((emit_req && emit_last) || cfg_we) begin
      length_left_nxt = eff_len(wl_sel);
      weight_left_nxt = eff_wt(wt_sel);
      run_offset_nxt  = '0;
      base_nxt        = '0;
      span_nxt        = '0;
      bits_nxt        = '0;
      partial_nxt     = '0;
      phase_nxt       = cwe_pkg::PH_CHOOSE;
      burst_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_length_r <= cwe_pkg::LEN_RST;
      weight_r      <= cwe_pkg::WT_RST;
      length_left_r <= LEN_RST_EFF;
      weight_left_r <= WT_RST_EFF;
      run_offset_r  <= '0;
      base_r        <= '0;
      span_r        <= '0;
      bits_r        <= '0;
      partial_r     <= '0;
      phase_r       <= cwe_pkg::PH_CHOOSE;
      burst_r       <= 1'b0;
    end else begin
      word_length_r <= word_length_nxt;
      weight_r      <= weight_nxt;
      length_left_r <= length_left_nxt;
      weight_left_r <= weight_left_nxt;
      run_offset_r  <= run_offset_nxt;
      base_r        <= base_nxt;
      span_r        <= span_nxt;
      bits_r        <= bits_nxt;
      partial_r     <= partial_nxt;
      phase_r       <= phase_nxt;
      burst_r       <= burst_nxt;
    end
  end

endmodule
